>>> rtl/assert_macros.svh
// Assertion macros used by joint_space_servo_torque.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/jsst_pkg.sv
// ----------------------------------------------------------------------------
// jsst_pkg
// Types and constants of the joint-space servo torque block.
// ----------------------------------------------------------------------------
package jsst_pkg;
	localparam int MAX_JOINTS = 16;
	localparam int VALUE_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int JW = $clog2(MAX_JOINTS);
	localparam int MW = 2 * JW;

	typedef enum logic [2:0] {
		REQ_GOAL = 3'd0, REQ_MEAS = 3'd1, REQ_GAIN = 3'd2,
		REQ_MASS = 3'd3, REQ_GRAV = 3'd4, REQ_COMPUTE = 3'd5
	} req_type_t;

	localparam logic [0:0] CFG_JOINTS = 1'b0;
	localparam logic [0:0] CFG_GRAVITY = 1'b1;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [3:0]         joint;
		logic [3:0]         column;
		logic signed [31:0] pos_term;
		logic signed [31:0] vel_term;
		logic signed [31:0] acc_term;
		logic signed [31:0] force_upper;
		logic signed [31:0] force_lower;
		logic signed [31:0] model_value;
	} req_t;

	typedef struct packed {
		logic [3:0]         out_joint;
		logic signed [31:0] torque;
		logic               last;
	} rsp_t;

	// saturate a wide signed sum to VALUE_BITS
	function automatic logic signed [VALUE_BITS-1:0] sat(input logic signed [71:0] s);
		logic signed [71:0] mx;
		logic signed [71:0] mn;
		mx = 72'(signed'({1'b0, {(VALUE_BITS-1){1'b1}}}));
		mn = -mx - 72'sd1;
		if (s > mx) return mx[VALUE_BITS-1:0];
		if (s < mn) return mn[VALUE_BITS-1:0];
		return s[VALUE_BITS-1:0];
	endfunction

	// product shifted right with truncation toward zero
	function automatic logic signed [71:0] trunc_shr(input logic signed [71:0] p);
		logic signed [71:0] q;
		q = p;
		if (p < 0) q = p + ((72'sd1 <<< FRAC_BITS) - 72'sd1);
		return q >>> FRAC_BITS;
	endfunction
endpackage

>>> rtl/jsst_ram.sv
// ----------------------------------------------------------------------------
// jsst_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jsst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/joint_space_servo_torque.sv
// Compute item: per joint, the task force is formed by a read, the
// products and a clamp; then, per joint, the torque: n mass reads, a drain
// of the read and multiply stages and the emit, which waits while a ready
// result is stalled. Load items are written while the block is idle.
// Reset clears control state, the task force table (via valid bits) and
// the registers to 16 joints, gravity on.
// ----------------------------------------------------------------------------
// joint_space_servo_torque
// Computed-torque PD servo: per-joint tables in RAMs, sequential compute.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module joint_space_servo_torque import jsst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  req_t       in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output rsp_t       out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [4:0] cfg_data
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001, ST_FRD = 6'b000010, ST_FMUL = 6'b000100,
		ST_FSUM = 6'b001000, ST_TACC = 6'b010000, ST_TOUT = 6'b100000
	} state_t;

	state_t state_q;
	logic [4:0] joints_q;
	logic       grav_q;
	logic [JW:0] n_w;
	logic [JW-1:0] i_q, k_q, k_s1;
	logic [MAX_JOINTS-1:0] tf_vld_q;
	logic signed [31:0] tf_q [MAX_JOINTS];
	logic signed [71:0] acc_q;
	logic signed [71:0] pa_q, pv_q, pp_q;
	logic rd_vld_s1, prod_vld_s2;
	rsp_t out_q;
	logic out_vld_q;

	// hold configuration while a compute is running
	assign cfg_ready = (state_q == ST_IDLE);
	assign n_w = (joints_q > 5'(MAX_JOINTS)) ? (JW+1)'(MAX_JOINTS) : joints_q[JW:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joints_q <= 5'd16;
			grav_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_JOINTS:  joints_q <= cfg_data;
				CFG_GRAVITY: grav_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic acc_in;
	assign acc_in = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	logic we_goal, we_meas, we_gain, we_mass, we_grav;
	assign we_goal = acc_in && in_data.req_type == REQ_GOAL;
	assign we_meas = acc_in && in_data.req_type == REQ_MEAS;
	assign we_gain = acc_in && in_data.req_type == REQ_GAIN;
	assign we_mass = acc_in && in_data.req_type == REQ_MASS;
	assign we_grav = acc_in && in_data.req_type == REQ_GRAV;

	logic [95:0]  goal_rd, meas_rd, gain_rd;
	logic [63:0]  lim_rd;
	logic [31:0]  mass_rd, grav_rd;
	logic [JW-1:0] jrd;
	logic [MW-1:0] mrd;

	jsst_ram #(.WIDTH(96), .DEPTH(MAX_JOINTS)) u_goal (.clk, .we(we_goal),
		.waddr(in_data.joint), .wdata({in_data.pos_term, in_data.vel_term, in_data.acc_term}),
		.raddr(jrd), .rdata(goal_rd));
	jsst_ram #(.WIDTH(96), .DEPTH(MAX_JOINTS)) u_meas (.clk, .we(we_meas),
		.waddr(in_data.joint), .wdata({in_data.pos_term, in_data.vel_term, in_data.acc_term}),
		.raddr(jrd), .rdata(meas_rd));
	jsst_ram #(.WIDTH(96), .DEPTH(MAX_JOINTS)) u_gain (.clk, .we(we_gain),
		.waddr(in_data.joint), .wdata({in_data.pos_term, in_data.vel_term, in_data.acc_term}),
		.raddr(jrd), .rdata(gain_rd));
	jsst_ram #(.WIDTH(64), .DEPTH(MAX_JOINTS)) u_lim (.clk, .we(we_gain),
		.waddr(in_data.joint), .wdata({in_data.force_upper, in_data.force_lower}),
		.raddr(jrd), .rdata(lim_rd));
	jsst_ram #(.WIDTH(32), .DEPTH(MAX_JOINTS)) u_grav (.clk, .we(we_grav),
		.waddr(in_data.joint), .wdata(in_data.model_value),
		.raddr(jrd), .rdata(grav_rd));
	jsst_ram #(.WIDTH(32), .DEPTH(MAX_JOINTS*MAX_JOINTS)) u_mass (.clk, .we(we_mass),
		.waddr({in_data.joint, in_data.column}), .wdata(in_data.model_value),
		.raddr(mrd), .rdata(mass_rd));

	assign jrd = i_q;
	assign mrd = {i_q, k_q};

	// task force terms
	logic signed [32:0] da, dv, dp;
	assign dp = 33'(signed'(goal_rd[95:64])) - 33'(signed'(meas_rd[95:64]));
	assign dv = 33'(signed'(goal_rd[63:32])) - 33'(signed'(meas_rd[63:32]));
	assign da = 33'(signed'(goal_rd[31:0])) - 33'(signed'(meas_rd[31:0]));

	logic signed [31:0] f_sat, f_up, f_lo, f_clamp, lim_up, lim_lo;
	assign lim_up = lim_rd[63:32];
	assign lim_lo = lim_rd[31:0];
	assign f_sat = sat(pa_q + pv_q + pp_q);
	assign f_up = (lim_up < f_sat) ? lim_up : f_sat;
	assign f_lo = (f_up < lim_lo) ? lim_lo : f_up;
	assign f_clamp = f_lo;

	// mass_rd belongs to the column read in the previous cycle, held in k_s1
	logic signed [31:0] tf_k;
	logic signed [71:0] mprod_s2;
	logic last_k;
	assign tf_k = tf_vld_q[k_s1] ? tf_q[k_s1] : 32'sd0;
	assign last_k = ((JW+1)'(k_q) + 1'b1) == n_w;
	logic last_i;
	assign last_i = ((JW+1)'(i_q) + 1'b1) == n_w;

	always_ff @(posedge clk) begin
		pa_q <= trunc_shr(72'(da) * 72'(signed'(gain_rd[31:0])));
		pv_q <= trunc_shr(72'(dv) * 72'(signed'(gain_rd[63:32])));
		pp_q <= trunc_shr(72'(dp) * 72'(signed'(gain_rd[95:64])));
		mprod_s2 <= trunc_shr(72'(signed'(mass_rd)) * 72'(tf_k));
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FSUM) tf_q[i_q] <= f_clamp;
	end

	logic out_free;
	assign out_free = !out_vld_q || !out_stall;

	logic emit;
	assign emit = (state_q == ST_TOUT) && !rd_vld_s1 && !prod_vld_s2 && out_free;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_joint <= 4'(i_q);
			out_q.torque <= sat(acc_q + (grav_q ? 72'(signed'(grav_rd)) : 72'sd0));
			out_q.last <= last_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			k_q <= '0;
			k_s1 <= '0;
			tf_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
			prod_vld_s2 <= 1'b0;
			out_vld_q <= 1'b0;
			acc_q <= '0;
		end else begin
			k_s1 <= k_q;
			rd_vld_s1 <= (state_q == ST_TACC);
			prod_vld_s2 <= rd_vld_s1;
			if (emit) out_vld_q <= 1'b1;
			else if (!out_stall) out_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					k_q <= '0;
					if (acc_in && in_data.req_type == REQ_COMPUTE && n_w != 0)
						state_q <= ST_FRD;
				end
				ST_FRD:  state_q <= ST_FMUL;
				ST_FMUL: state_q <= ST_FSUM;
				ST_FSUM: begin
					tf_vld_q[i_q] <= 1'b1;
					if (last_i) begin
						i_q <= '0;
						state_q <= ST_TACC;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= ST_FRD;
					end
					acc_q <= '0;
				end
				ST_TACC: begin
					// read one mass entry per cycle; each product reaches acc_q through the RAM read register and mprod_s2
					if (prod_vld_s2) acc_q <= acc_q + mprod_s2;
					if (last_k) state_q <= ST_TOUT;
					else k_q <= k_q + 1'b1;
				end
				ST_TOUT: begin
					// drain the read and multiply stages, then emit
					if (prod_vld_s2) acc_q <= acc_q + mprod_s2;
					else if (emit) begin
						acc_q <= '0;
						k_q <= '0;
						if (last_i) state_q <= ST_IDLE;
						else begin
							i_q <= i_q + 1'b1;
							state_q <= ST_TACC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_vld_q;
	assign out_data = out_q;

	`ASSERT_IMPLIES(a_busy_stall, clk, arst_n, state_q != ST_IDLE, in_stall)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`ASSERT_NEXT(a_start, clk, arst_n,
		acc_in && in_data.req_type == REQ_COMPUTE && n_w != 0, state_q == ST_FRD)
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives load and compute items into the servo block with random idling on
// both sides, predicts each torque from its own copy of the tables, and checks
// every result in order against the queue of predicted torques.
// ----------------------------------------------------------------------------
module tb_top;
	import jsst_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	req_t       in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	rsp_t       out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [0:0] cfg_index = CFG_JOINTS;
	logic [4:0] cfg_data = '0;

	joint_space_servo_torque uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow state
	logic signed [31:0] g_pos [16], g_vel [16], g_acc [16];
	logic signed [31:0] m_pos [16], m_vel [16], m_acc [16];
	logic signed [31:0] kp [16], kv [16], ka [16], f_hi [16], f_lo [16];
	logic signed [31:0] mass [16][16];
	logic signed [31:0] grav [16];
	logic signed [31:0] tforce [16];
	int unsigned        active_joints;
	bit                 grav_en;

	rsp_t torque_q [$];
	int   errors;
	bit   quiet;

	function automatic logic signed [127:0] scaled(logic signed [127:0] x,
			logic signed [127:0] y);
		logic signed [127:0] p;
		logic [127:0]        mag;
		p = x * y;
		mag = p < 0 ? -p : p;
		mag = mag >> FRAC_BITS;
		return p < 0 ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [31:0] clip32(logic signed [127:0] s);
		if (s > 128'sh7fffffff) return 32'sh7fffffff;
		if (s < -128'sh80000000) return 32'sh80000000;
		return s[31:0];
	endfunction

	task automatic predict_item(req_t r);
		logic signed [127:0] s;
		logic signed [31:0]  f;
		int unsigned         n;
		rsp_t                t;
		case (r.req_type)
			REQ_GOAL: begin
				g_pos[r.joint] = r.pos_term; g_vel[r.joint] = r.vel_term;
				g_acc[r.joint] = r.acc_term;
			end
			REQ_MEAS: begin
				m_pos[r.joint] = r.pos_term; m_vel[r.joint] = r.vel_term;
				m_acc[r.joint] = r.acc_term;
			end
			REQ_GAIN: begin
				kp[r.joint] = r.pos_term; kv[r.joint] = r.vel_term;
				ka[r.joint] = r.acc_term;
				f_hi[r.joint] = r.force_upper; f_lo[r.joint] = r.force_lower;
			end
			REQ_MASS: mass[r.joint][r.column] = r.model_value;
			REQ_GRAV: grav[r.joint] = r.model_value;
			REQ_COMPUTE: begin
				n = active_joints > 16 ? 16 : active_joints;
				for (int i = 0; i < n; i++) begin
					s = scaled(128'(g_acc[i]) - 128'(m_acc[i]), 128'(ka[i]))
						+ scaled(128'(g_vel[i]) - 128'(m_vel[i]), 128'(kv[i]))
						+ scaled(128'(g_pos[i]) - 128'(m_pos[i]), 128'(kp[i]));
					f = clip32(s);
					if (f > f_hi[i]) f = f_hi[i];
					if (f < f_lo[i]) f = f_lo[i];
					tforce[i] = f;
				end
				for (int i = 0; i < n; i++) begin
					s = 0;
					for (int k = 0; k < n; k++)
						s += scaled(128'(mass[i][k]), 128'(tforce[k]));
					if (grav_en) s += 128'(grav[i]);
					t.out_joint = i[3:0];
					t.torque = clip32(s);
					t.last = (i + 1 == n);
					torque_q.push_back(t);
				end
			end
			default: ;
		endcase
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	// check each result transaction against the oldest prediction
	always @(posedge clk) begin
		rsp_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (torque_q.size() == 0) begin
				report("unexpected result", 64'(out_data), 64'd0);
			end else begin
				w = torque_q.pop_front();
				if (out_data.out_joint !== w.out_joint)
					report("out_joint", 64'(out_data.out_joint), 64'(w.out_joint));
				if (out_data.torque !== w.torque)
					report("torque", 64'(out_data.torque), 64'(w.torque));
				if (out_data.last !== w.last)
					report("last", 64'(out_data.last), 64'(w.last));
			end
		end
	end

	// receiver stalls in bursts
	always @(negedge clk) begin
		int burst;
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (burst > 0) begin
			burst--;
			if (burst == 0) out_stall <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			burst = $urandom_range(1, 5);
			out_stall <= 1'b1;
		end
	end

	// valid stays high after the transaction; the next item or drain updates it
	task automatic send_item(req_t r);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_item(r);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (torque_q.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [4:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_JOINTS) active_joints = val; else grav_en = val[0];
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rnd_value(int mode);
		case (mode)
			0: return $urandom_range(0, 3) == 0 ? 32'sh7fffffff : 32'sh80000000;
			1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t rnd_load(logic [2:0] kind, logic [3:0] j, logic [3:0] c,
			int mode);
		req_t r;
		r.req_type = kind; r.joint = j; r.column = c;
		r.pos_term = rnd_value(mode); r.vel_term = rnd_value(mode);
		r.acc_term = rnd_value(mode); r.force_upper = rnd_value(mode);
		r.force_lower = rnd_value(mode); r.model_value = rnd_value(mode);
		return r;
	endfunction

	// write every entry of the first eight joints; no compute uses more
	task automatic fill_tables(int mode);
		for (int j = 0; j < 8; j++) begin
			send_item(rnd_load(REQ_GOAL, 4'(j), 4'($urandom), mode));
			send_item(rnd_load(REQ_MEAS, 4'(j), 4'($urandom), mode));
			send_item(rnd_load(REQ_GAIN, 4'(j), 4'($urandom), mode));
			send_item(rnd_load(REQ_GRAV, 4'(j), 4'($urandom), mode));
			for (int c = 0; c < 8; c++) send_item(rnd_load(REQ_MASS, 4'(j), 4'(c), mode));
		end
	endtask

	function automatic req_t compute_req();
		req_t r;
		r = rnd_load(REQ_COMPUTE, 4'($urandom), 4'($urandom), 2);
		return r;
	endfunction

	task automatic test_directed();
		req_t r;
		fill_tables(1);
		send_item(compute_req());
		drain();
		// extremes: saturation both ways, crossed limits
		r = rnd_load(REQ_GAIN, 4'd0, 4'd0, 0);
		r.force_upper = 32'sh80000000; r.force_lower = 32'sh7fffffff;
		send_item(r);
		send_item(rnd_load(REQ_GOAL, 4'd1, 4'd0, 0));
		send_item(rnd_load(REQ_MEAS, 4'd1, 4'd0, 0));
		send_item(rnd_load(REQ_GAIN, 4'd2, 4'd0, 0));
		send_item(rnd_load(REQ_MASS, 4'd3, 4'd7, 0));
		send_item(rnd_load(REQ_GRAV, 4'd7, 4'd0, 0));
		r = compute_req(); r.req_type = 3'd6; send_item(r);
		r.req_type = 3'd7; send_item(r);
		send_item(compute_req());
		drain();
		write_reg(CFG_JOINTS, 5'd0);
		send_item(compute_req());
		drain();
		write_reg(CFG_JOINTS, 5'd8);
		write_reg(CFG_GRAVITY, 5'd0);
		send_item(compute_req());
		drain();
		write_reg(CFG_JOINTS, 5'd1);
		write_reg(CFG_GRAVITY, 5'd1);
		send_item(compute_req());
		drain();
		write_reg(CFG_JOINTS, 5'd8);
	endtask

	task automatic test_random(int count);
		int   mode;
		req_t r;
		for (int k = 0; k < count; k++) begin
			mode = $urandom_range(0, 2);
			if ($urandom_range(0, 4) == 0) begin
				r = compute_req();
				if ($urandom_range(0, 7) == 0) r.req_type = 3'($urandom_range(6, 7));
			end else if ($urandom_range(0, 1) == 0) begin
				r = rnd_load(REQ_MASS, 4'($urandom), 4'($urandom), mode);
			end else begin
				r = rnd_load(3'($urandom_range(0, 4)), 4'($urandom), 4'($urandom), mode);
			end
			send_item(r);
		end
		drain();
	endtask

	task automatic test_settings();
		write_reg(CFG_JOINTS, 5'($urandom_range(2, 8)));
		write_reg(CFG_GRAVITY, 5'($urandom_range(0, 1)));
		test_random(40);
		write_reg(CFG_JOINTS, 5'd8);
		write_reg(CFG_GRAVITY, 5'd1);
		quiet = 1'b1;
		test_random(40);
	endtask

	initial begin
		active_joints = 16;
		grav_en = 1'b1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		write_reg(CFG_JOINTS, 5'd8);
		test_directed();
		test_random(80);
		test_settings();
		if (errors == 0) $display("joint_space_servo_torque regression: pass");
		else $display("joint_space_servo_torque regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("joint_space_servo_torque regression: fail");
		$finish;
	end
endmodule

>>> joint_space_servo_torque.f
+incdir+rtl
rtl/jsst_pkg.sv
rtl/jsst_ram.sv
rtl/joint_space_servo_torque.sv
tb/sv/tb_top.sv
